// ----- src/tbpd_pkg.sv -----
// Shared constants, types and floor-diamond tables for the tile block pixel decoder.
`timescale 1ns / 1ps

package tbpd_pkg;

  localparam int unsigned TileWidth     = 160;
  localparam int unsigned MaxTileHeight = 4096;
  localparam int unsigned FloorBytes    = 256;
  localparam int unsigned FloorRows     = 15;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] RegBlockFormat = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBlockX      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBlockY      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegYOffset     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTileHeight  = 3'd4;

  localparam logic [12:0] TileHeightReset = 13'd80;

  // run-length decode phases
  localparam logic [1:0] PhaseSkip  = 2'd0;
  localparam logic [1:0] PhaseDraw  = 2'd1;
  localparam logic [1:0] PhasePixel = 2'd2;

  // pixel position in block space, ahead of tile mapping
  typedef struct packed {
    logic [15:0] col;
    logic [11:0] row;
    logic [7:0]  idx;
  } pix_req_t;

  typedef struct packed {
    logic signed [10:0] block_x;
    logic signed [11:0] block_y;
    logic [11:0]        y_offset;
    logic [12:0]        tile_height;
  } map_cfg_t;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [11:0] pixel_y;
    logic [21:0] pixel_address;
    logic [7:0]  color_index;
    logic        transparent;
    logic        out_of_range;
  } pix_res_t;

  function automatic logic [3:0] floor_start(input logic [3:0] row);
    logic [3:0] s;
    unique case (row)
      4'd0, 4'd14: s = 4'd14;
      4'd1, 4'd13: s = 4'd12;
      4'd2, 4'd12: s = 4'd10;
      4'd3, 4'd11: s = 4'd8;
      4'd4, 4'd10: s = 4'd6;
      4'd5, 4'd9:  s = 4'd4;
      4'd6, 4'd8:  s = 4'd2;
      default:     s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [5:0] floor_count(input logic [3:0] row);
    logic [5:0] c;
    unique case (row)
      4'd0, 4'd14: c = 6'd4;
      4'd1, 4'd13: c = 6'd8;
      4'd2, 4'd12: c = 6'd12;
      4'd3, 4'd11: c = 6'd16;
      4'd4, 4'd10: c = 6'd20;
      4'd5, 4'd9:  c = 6'd24;
      4'd6, 4'd8:  c = 6'd28;
      4'd7:        c = 6'd32;
      default:     c = 6'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- src/tbpd_in_if.sv -----
// Byte stream channel into the tile block pixel decoder.
`timescale 1ns / 1ps

interface tbpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

// ----- src/tbpd_out_if.sv -----
// Pixel write channel out of the tile block pixel decoder.
`timescale 1ns / 1ps

interface tbpd_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  pixel_x;
  logic [11:0] pixel_y;
  logic [21:0] pixel_address;
  logic [7:0]  color_index;
  logic        transparent;
  logic        out_of_range;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_address,
                  output color_index, output transparent, output out_of_range,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_address,
                  input color_index, input transparent, input out_of_range,
                  output ready);
endinterface

// ----- src/tbpd_seq.sv -----
// Block decoder state: run-length phases, floor diamond walk, column and row counters.
`timescale 1ns / 1ps

module tbpd_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               block_start_i,
  input  logic               block_format_i,
  output logic               emit_o,
  output tbpd_pkg::pix_req_t req_o
);

  logic [1:0]  phase_q, phase_d;
  logic [15:0] col_q, col_d;
  logic [11:0] row_q, row_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  skip_q, skip_d;
  logic [8:0]  seen_q, seen_d;

  // state as seen by this byte, after a block start clears it
  logic [1:0]  phase_c;
  logic [15:0] col_c;
  logic [11:0] row_c;
  logic [7:0]  left_c;
  logic [7:0]  skip_c;
  logic [8:0]  seen_c;

  logic [15:0] col_inc;
  logic [7:0]  left_dec;
  logic [3:0]  frow;
  logic        frow_ok;

  always_comb begin
    if (block_start_i) begin
      phase_c = tbpd_pkg::PhaseSkip;
      col_c   = '0;
      row_c   = '0;
      left_c  = '0;
      skip_c  = '0;
      seen_c  = '0;
    end else begin
      phase_c = phase_q;
      col_c   = col_q;
      row_c   = row_q;
      left_c  = left_q;
      skip_c  = skip_q;
      seen_c  = seen_q;
    end
  end

  assign col_inc  = col_c + 16'd1;
  assign left_dec = left_c - 8'd1;
  assign frow     = row_c[3:0];
  assign frow_ok  = (row_c < 12'(tbpd_pkg::FloorRows));

  always_comb begin
    phase_d = phase_c;
    col_d   = col_c;
    row_d   = row_c;
    left_d  = left_c;
    skip_d  = skip_c;
    seen_d  = seen_c;
    emit_o  = 1'b0;
    req_o.col = col_c;
    req_o.row = row_c;
    req_o.idx = data_byte_i;

    if (block_format_i) begin
      if (seen_c < 9'(tbpd_pkg::FloorBytes)) begin
        seen_d = seen_c + 9'd1;
        if (frow_ok) begin
          emit_o    = 1'b1;
          req_o.col = col_c + 16'(tbpd_pkg::floor_start(frow));
          if (col_inc >= 16'(tbpd_pkg::floor_count(frow))) begin
            col_d = '0;
            row_d = row_c + 12'd1;
          end else begin
            col_d = col_inc;
          end
        end
      end
    end else begin
      unique case (phase_c)
        tbpd_pkg::PhaseDraw: begin
          if (skip_c == 8'd0 && data_byte_i == 8'd0) begin
            col_d   = '0;
            row_d   = row_c + 12'd1;
            phase_d = tbpd_pkg::PhaseSkip;
          end else begin
            col_d   = col_c + 16'(skip_c);
            left_d  = data_byte_i;
            phase_d = (data_byte_i != 8'd0) ? tbpd_pkg::PhasePixel : tbpd_pkg::PhaseSkip;
          end
        end
        tbpd_pkg::PhasePixel: begin
          emit_o = 1'b1;
          col_d  = col_inc;
          left_d = left_dec;
          if (left_dec == 8'd0) begin
            phase_d = tbpd_pkg::PhaseSkip;
          end
        end
        default: begin
          // skip byte; the unused code lands here as well
          skip_d  = data_byte_i;
          phase_d = tbpd_pkg::PhaseDraw;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tbpd_pkg::PhaseSkip;
      col_q   <= '0;
      row_q   <= '0;
      left_q  <= '0;
      skip_q  <= '0;
      seen_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
      left_q  <= left_d;
      skip_q  <= skip_d;
      seen_q  <= seen_d;
    end
  end

endmodule

// ----- src/tbpd_map.sv -----
// Maps a block-space pixel to tile coordinates, bounds check and linear address.
`timescale 1ns / 1ps

module tbpd_map (
  input  tbpd_pkg::pix_req_t req_i,
  input  tbpd_pkg::map_cfg_t cfg_i,
  output tbpd_pkg::pix_res_t res_o
);

  logic signed [17:0] tx;
  logic signed [14:0] ty;
  logic [12:0]        h_lim;
  logic               oor;
  logic [23:0]        addr;

  assign tx = $signed({2'b00, req_i.col}) + 18'(cfg_i.block_x);
  assign ty = $signed({3'b000, req_i.row}) + $signed({3'b000, cfg_i.y_offset})
            + 15'(cfg_i.block_y);

  assign h_lim = (cfg_i.tile_height > 13'(tbpd_pkg::MaxTileHeight))
               ? 13'(tbpd_pkg::MaxTileHeight) : cfg_i.tile_height;

  assign oor = tx[17] || (tx[16:0] >= 17'(tbpd_pkg::TileWidth))
            || ty[14] || (ty[13:0] >= {1'b0, h_lim});

  // 12 x 8 bit constant product, fits the address width before truncation
  assign addr = 24'(ty[11:0]) * 24'(tbpd_pkg::TileWidth) + 24'(tx[9:0]);

  always_comb begin
    res_o.color_index = req_i.idx;
    res_o.transparent = (req_i.idx == 8'd0);
    res_o.out_of_range = oor;
    if (oor) begin
      res_o.pixel_x       = '0;
      res_o.pixel_y       = '0;
      res_o.pixel_address = '0;
    end else begin
      res_o.pixel_x       = tx[9:0];
      res_o.pixel_y       = ty[11:0];
      res_o.pixel_address = addr[21:0];
    end
  end

endmodule

// ----- src/tile_block_pixel_decoder.sv -----
// Top level of the tile block pixel decoder: config registers, pipeline and output register.
// A pixel byte's result passes through the stage register s1_q, then the output register out_q.
// Throughput: one byte per cycle while in_i.ready is high; the decoder counters update in the transfer cycle.
// Skip, draw and surplus floor bytes give no result but are still accepted as input transfers.
// Input stalls only when stage and output registers both hold pixels and output is not taken.
// Reset clears the decoder state and pipeline valids; tile_height resets to 80, others to 0.
`timescale 1ns / 1ps

module tile_block_pixel_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tbpd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tbpd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  tbpd_in_if.sink                        in_i,
  tbpd_out_if.source                     out_o
);

  logic               block_format_q;
  tbpd_pkg::map_cfg_t cfg_q;

  logic               in_xfer;
  logic               advance;
  logic               emit;
  tbpd_pkg::pix_req_t req;
  logic               s1_valid_q;
  tbpd_pkg::pix_req_t s1_q;
  tbpd_pkg::pix_res_t res;
  logic               out_valid_q;
  tbpd_pkg::pix_res_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_format_q    <= 1'b0;
      cfg_q.block_x     <= '0;
      cfg_q.block_y     <= '0;
      cfg_q.y_offset    <= '0;
      cfg_q.tile_height <= tbpd_pkg::TileHeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbpd_pkg::RegBlockFormat: block_format_q    <= cfg_wdata_i[0];
        tbpd_pkg::RegBlockX:      cfg_q.block_x     <= cfg_wdata_i[10:0];
        tbpd_pkg::RegBlockY:      cfg_q.block_y     <= cfg_wdata_i[11:0];
        tbpd_pkg::RegYOffset:     cfg_q.y_offset    <= cfg_wdata_i[11:0];
        tbpd_pkg::RegTileHeight:  cfg_q.tile_height <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_xfer  = in_i.valid && in_i.ready;

  tbpd_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_xfer),
    .data_byte_i    (in_i.data_byte),
    .block_start_i  (in_i.block_start),
    .block_format_i (block_format_q),
    .emit_o         (emit),
    .req_o          (req)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_xfer && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      s1_q <= req;
    end
  end

  tbpd_map u_map (
    .req_i (s1_q),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pixel_x       = out_q.pixel_x;
  assign out_o.pixel_y       = out_q.pixel_y;
  assign out_o.pixel_address = out_q.pixel_address;
  assign out_o.color_index   = out_q.color_index;
  assign out_o.transparent   = out_q.transparent;
  assign out_o.out_of_range  = out_q.out_of_range;

endmodule

// ----- sim/tile_block_pixel_decoder_test.sv -----
// Self-checking testbench for the tile block pixel decoder: predicts every pixel write.
`timescale 1ns / 1ps

module tile_block_pixel_decoder_test;

  localparam int IdleNone     = 0;
  localparam int IdleSender   = 1;
  localparam int IdleReceiver = 2;
  localparam int IdleBoth     = 3;
  localparam int SenderIdlePct[4]    = '{0, 54, 0, 18};
  localparam int ReceiverStallPct[4] = '{0, 0, 54, 18};

  // covers the stage and output registers plus margin
  localparam int SettleCycles  = 4;
  // longest legal quiet stretch is the LongHold receiver hold-off
  localparam int WatchdogLimit = 2000;
  localparam int LongHold      = 300;

  localparam logic [3:0] DiamondStart[tbpd_pkg::FloorRows] =
    '{14, 12, 10, 8, 6, 4, 2, 0, 2, 4, 6, 8, 10, 12, 14};
  localparam logic [5:0] DiamondWidth[tbpd_pkg::FloorRows] =
    '{4, 8, 12, 16, 20, 24, 28, 32, 28, 24, 20, 16, 12, 8, 4};

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } stream_byte_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [tbpd_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [tbpd_pkg::CfgDataW-1:0] cfg_wdata;

  tbpd_in_if  in_if ();
  tbpd_out_if out_if ();

  tile_block_pixel_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if.sink),
    .out_o       (out_if.source)
  );

  // register copies
  logic               cfg_floor       = 1'b0;
  logic signed [10:0] cfg_block_x     = '0;
  logic signed [11:0] cfg_block_y     = '0;
  logic [11:0]        cfg_y_offset    = '0;
  logic [12:0]        cfg_tile_height = tbpd_pkg::TileHeightReset;

  // decoder state
  logic [1:0]  rl_phase   = tbpd_pkg::PhaseSkip;
  logic [15:0] col_cnt    = '0;
  logic [11:0] row_cnt    = '0;
  logic [7:0]  run_left   = '0;
  logic [7:0]  skip_hold  = '0;
  logic [8:0]  floor_seen = '0;

  stream_byte_t         byte_queue[$];
  tbpd_pkg::pix_res_t   pixel_queue[$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int receiver_hold      = 0;
  int quiet_cycles       = 0;
  int mismatches         = 0;
  int pixels_checked     = 0;
  int bytes_sent         = 0;
  int settings_used      = 0;

  function automatic bit roll(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic int rnd(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic tbpd_pkg::pix_res_t place_pixel(input logic [15:0] col,
                                                     input logic [11:0] row,
                                                     input logic [7:0] idx);
    int                 tx;
    int                 ty;
    int                 rows;
    tbpd_pkg::pix_res_t px;
    tx   = int'(col) + int'(cfg_block_x);
    ty   = int'(row) + int'(cfg_y_offset) + int'(cfg_block_y);
    rows = int'(cfg_tile_height);
    if (rows > int'(tbpd_pkg::MaxTileHeight)) rows = int'(tbpd_pkg::MaxTileHeight);
    px = '0;
    px.color_index = idx;
    px.transparent = (idx == 8'd0);
    if (tx < 0 || tx >= int'(tbpd_pkg::TileWidth) || ty < 0 || ty >= rows) begin
      px.out_of_range = 1'b1;
    end else begin
      px.pixel_x       = 10'(tx);
      px.pixel_y       = 12'(ty);
      px.pixel_address = 22'(ty * int'(tbpd_pkg::TileWidth) + tx);
    end
    return px;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic first);
    logic [15:0] col;
    if (first) begin
      rl_phase   = tbpd_pkg::PhaseSkip;
      col_cnt    = '0;
      row_cnt    = '0;
      run_left   = '0;
      skip_hold  = '0;
      floor_seen = '0;
    end
    if (cfg_floor) begin
      // surplus bytes are dropped uncounted; rows past the diamond are counted but silent
      if (floor_seen >= tbpd_pkg::FloorBytes) return;
      floor_seen = floor_seen + 9'd1;
      if (row_cnt >= tbpd_pkg::FloorRows) return;
      col = col_cnt + 16'(DiamondStart[row_cnt[3:0]]);
      pixel_queue.push_back(place_pixel(col, row_cnt, b));
      col_cnt = col_cnt + 16'd1;
      if (col_cnt >= 16'(DiamondWidth[row_cnt[3:0]])) begin
        col_cnt = '0;
        row_cnt = row_cnt + 12'd1;
      end
      return;
    end
    case (rl_phase)
      tbpd_pkg::PhaseDraw: begin
        if (skip_hold == 8'd0 && b == 8'd0) begin
          col_cnt  = '0;
          row_cnt  = row_cnt + 12'd1;
          rl_phase = tbpd_pkg::PhaseSkip;
        end else begin
          col_cnt  = col_cnt + 16'(skip_hold);
          run_left = b;
          rl_phase = (b != 8'd0) ? tbpd_pkg::PhasePixel : tbpd_pkg::PhaseSkip;
        end
      end
      tbpd_pkg::PhasePixel: begin
        pixel_queue.push_back(place_pixel(col_cnt, row_cnt, b));
        col_cnt  = col_cnt + 16'd1;
        run_left = run_left - 8'd1;
        if (run_left == 8'd0) rl_phase = tbpd_pkg::PhaseSkip;
      end
      default: begin
        skip_hold = b;
        rl_phase  = tbpd_pkg::PhaseDraw;
      end
    endcase
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic put(input int b, input bit first = 1'b0);
    stream_byte_t sb;
    sb.data  = 8'(b);
    sb.first = first;
    byte_queue.push_back(sb);
  endtask

  task automatic queue_rle_block(input int rows);
    int draw;
    bit lead;
    lead = 1'b1;
    for (int r = 0; r < rows; r++) begin
      for (int k = rnd(0, 3); k > 0; k--) begin
        put(roll(5) ? 255 : rnd(0, 30), lead);
        lead = 1'b0;
        draw = roll(8) ? 0 : (roll(3) ? rnd(100, 255) : rnd(1, 12));
        put(draw);
        for (int p = 0; p < draw; p++) put(roll(15) ? 0 : rnd(0, 255));
      end
      put(0, lead);
      lead = 1'b0;
      put(0);
    end
  endtask

  task automatic queue_floor_block(input int len);
    for (int i = 0; i < len; i++) put(rnd(0, 255), i == 0);
  endtask

  task automatic queue_noise(input int len);
    repeat (len) put(rnd(0, 255), roll(12));
  endtask

  task automatic write_reg(input logic [tbpd_pkg::CfgIdxW-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= tbpd_pkg::CfgDataW'(value);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input bit floor_fmt, input int bx, input int by, input int yoff,
                           input int th);
    write_reg(tbpd_pkg::RegBlockFormat, floor_fmt);
    write_reg(tbpd_pkg::RegBlockX, bx);
    write_reg(tbpd_pkg::RegBlockY, by);
    write_reg(tbpd_pkg::RegYOffset, yoff);
    write_reg(tbpd_pkg::RegTileHeight, th);
    cfg_floor       = floor_fmt;
    cfg_block_x     = 11'(bx);
    cfg_block_y     = 12'(by);
    cfg_y_offset    = 12'(yoff);
    cfg_tile_height = 13'(th);
    settings_used++;
  endtask

  // sender stays quiet until every predicted pixel has come back
  task automatic drain();
    do @(negedge clk_i);
    while (byte_queue.size() != 0 || in_if.valid || pixel_queue.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic traffic_phase(input bit floor_fmt, input int bx, input int by, input int yoff,
                               input int th, input int idle, input int budget, input int hold);
    int pick;
    configure(floor_fmt, bx, by, yoff, th);
    sender_idle_pct    = SenderIdlePct[idle];
    receiver_stall_pct = ReceiverStallPct[idle];
    if (hold != 0) begin
      // a long run so the pipeline fills up behind the held receiver
      put(0, 1'b1);
      put(24);
      repeat (24) put(rnd(0, 255));
    end
    while (byte_queue.size() < budget) begin
      pick = rnd(0, 99);
      if (pick < 75) begin
        if (floor_fmt) queue_floor_block(rnd(4, 60));
        else queue_rle_block(rnd(1, 3));
      end else if (pick < 88) begin
        queue_noise(rnd(1, 8));
      end else begin
        // block cut short, usually mid-run
        queue_rle_block(1);
        repeat (rnd(1, 4)) if (byte_queue.size() != 0) void'(byte_queue.pop_back());
      end
    end
    receiver_hold = hold;
    drain();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : byte_driver
    stream_byte_t pending;
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.data_byte   <= '0;
      in_if.block_start <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.data_byte, in_if.block_start);
        bytes_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (byte_queue.size() != 0 && !roll(sender_idle_pct)) begin
          pending = byte_queue.pop_front();
          in_if.valid       <= 1'b1;
          in_if.data_byte   <= pending.data;
          in_if.block_start <= pending.first;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : pixel_sink
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (receiver_hold != 0) begin
      receiver_hold--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !roll(receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin : pixel_monitor
    tbpd_pkg::pix_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pixel_queue.size() == 0) begin
        $error("pixel write x=%0d y=%0d idx=%0d with none expected",
               out_if.pixel_x, out_if.pixel_y, out_if.color_index);
        mismatches++;
      end else begin
        want = pixel_queue.pop_front();
        pixels_checked++;
        check_field("pixel_x", want.pixel_x, out_if.pixel_x);
        check_field("pixel_y", want.pixel_y, out_if.pixel_y);
        check_field("pixel_address", want.pixel_address, out_if.pixel_address);
        check_field("color_index", want.color_index, out_if.color_index);
        check_field("transparent", want.transparent, out_if.transparent);
        check_field("out_of_range", want.out_of_range, out_if.out_of_range);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL tile_block_pixel_decoder");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values, hand-built run-length stream
    put(0, 1'b1); put(3); put(0); put(255); put(128);
    put(5); put(0);                        // skip with no draw: column only
    put(2); put(2); put(1); put(254);
    put(0); put(0);                        // next row
    put(7); put(4); put(85); put(170);
    put(9, 1'b1); put(1); put(15);         // new block mid-run
    put(0); put(0);
    put(255); put(1); put(99);             // column past the tile edge
    drain();

    // full floor diamond plus surplus bytes
    configure(1'b1, 0, 0, 0, 80);
    queue_floor_block(260);
    drain();
    // format switches inside a block keep the shared counters
    configure(1'b0, 0, 0, 0, 80);
    put(2); put(2); put(17); put(34);
    drain();
    put(0, 1'b1); put(0); put(0); put(0); put(0); put(0);
    put(200); put(0);
    drain();
    configure(1'b1, 0, 0, 0, 80);
    repeat (3) put(rnd(0, 255));
    drain();
    configure(1'b0, 0, 0, 0, 80);
    for (int i = 0; i < 16; i++) begin
      put(0, i == 0);
      put(0);
    end
    drain();
    configure(1'b1, 0, 0, 0, 80);
    repeat (3) put(rnd(0, 255));
    drain();

    // register extremes
    traffic_phase(1'b0, -1024, -2048, 4095, 8191, IdleSender, 1, 0);
    traffic_phase(1'b1, 1023, 2047, 2048, 4096, IdleReceiver, 1, 0);
    traffic_phase(1'b0, -10, -5, 0, 0, IdleBoth, 1, 0);
    traffic_phase(1'b0, 150, 70, 5, 80, IdleNone, 1, 0);
    traffic_phase(1'b0, 100, 2047, 2048, 4096, IdleNone, 1, 0);
    traffic_phase(1'b1, -14, -1, 0, 4096, IdleBoth, 1, 0);

    // random blocks; first phase holds the receiver off while bytes keep coming
    for (int ph = 0; ph < 3; ph++) begin
      traffic_phase(ph % 3 == 1, rnd(-40, 150), rnd(-20, 60), rnd(0, 40),
                    roll(25) ? 4096 : rnd(60, 200), ph % 4, 10, ph == 0 ? LongHold : 0);
    end

    $display("Sent %0d stream bytes, checked %0d pixel writes under %0d register settings:",
             bytes_sent, pixels_checked, settings_used);
    $display("both formats, mid-block format switches, off-tile positions, idle mixes, a long hold.");
    if (mismatches == 0) $display("PASS tile_block_pixel_decoder");
    else $display("FAIL tile_block_pixel_decoder");
    $finish;
  end

endmodule

// ----- files.f -----
src/tbpd_pkg.sv
src/tbpd_in_if.sv
src/tbpd_out_if.sv
src/tbpd_seq.sv
src/tbpd_map.sv
src/tile_block_pixel_decoder.sv
sim/tile_block_pixel_decoder_test.sv
